>>> src/bab_pkg.sv
package bab_pkg;

	// Default number of blocks tracked by the bitmap
	localparam int BLOCK_COUNT_DEF = 256;

	// Field widths of the command and response
	localparam int MODE_W    = 2;
	localparam int BIDX_W    = 9;
	localparam int STATUS_W  = 2;
	localparam int GRANT_W   = 8;
	localparam int COUNT_W   = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_REQUEST = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_USED    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [BIDX_W-1:0]  block_index;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [GRANT_W-1:0] granted_index;
		logic [COUNT_W-1:0] used_count;
		logic [COUNT_W-1:0] free_count;
	} rsp_t;

endpackage

>>> src/bab_first_free.sv
module bab_first_free import bab_pkg::*; #(
	parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
	input  logic [BLOCK_COUNT-1:0]         map,
	output logic                           found,
	output logic [$clog2(BLOCK_COUNT)-1:0] index
);

	localparam int IDX_W = $clog2(BLOCK_COUNT);

	logic [BLOCK_COUNT-1:0] free_vec;
	logic [BLOCK_COUNT-1:0] lowest;

	// Isolate the lowest free block as a one-hot vector
	assign free_vec = ~map;
	assign lowest   = free_vec & (~free_vec + BLOCK_COUNT'(1));
	assign found    = |free_vec;

	// Encode the one-hot vector: each index bit is an OR over its positions
	always_comb begin
		index = '0;
		for (int i = 0; i < BLOCK_COUNT; i++) begin
			for (int j = 0; j < IDX_W; j++) begin
				if (((i >> j) & 1) == 1) begin
					index[j] = index[j] | lowest[i];
				end
			end
		end
	end

endmodule

>>> src/block_allocation_bitmap.sv
// Block allocation bitmap.
// Tracks one in-use bit per block and a count of used blocks.
// Command channel (cmd_valid/cmd_ready/cmd): mode is allocate lowest free,
// request a named block or release a named block.
// Response channel (rsp_valid/rsp_ready/rsp): one response per command with
// status, granted index (allocate only) and the used and free counts after it.
// A command accepted into the command register is executed from there, and
// its result lands in the response register once the response slot frees.
// Throughput: one command per cycle while the receiver does not stall; the
// bitmap search, mark and count update for a command are combinational
// between the two registers.
// When the receiver stalls, the response register holds and the command
// register holds behind it; cmd_ready drops only when both are full, so no
// transaction is lost or repeated.
// Reset clears the bitmap (all blocks free), the count and both valid flags;
// the block takes commands as soon as reset is released.
module block_allocation_bitmap import bab_pkg::*; #(
	parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(BLOCK_COUNT);
	localparam int CNT_W = $clog2(BLOCK_COUNT + 1);

	logic                   cmd_vld_s1;
	cmd_t                   cmd_s1;
	logic                   rsp_vld_q;
	rsp_t                   rsp_q;
	logic [BLOCK_COUNT-1:0] map_q;
	logic [BLOCK_COUNT-1:0] map_d;
	logic [CNT_W-1:0]       used_q;
	logic [CNT_W-1:0]       used_d;
	logic                   advance;
	logic                   ff_found;
	logic [IDX_W-1:0]       ff_index;
	logic [31:0]            idx_wide;
	logic                   in_range;
	logic [IDX_W-1:0]       sel;
	status_t                status;
	logic [IDX_W-1:0]       grant;
	rsp_t                   rsp_d;

	// Handshake: the command stage moves on whenever the response slot frees
	assign advance   = cmd_vld_s1 && (!rsp_vld_q || rsp_ready);
	assign cmd_ready = !cmd_vld_s1 || advance;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Lowest free block search
	bab_first_free #(
		.BLOCK_COUNT (BLOCK_COUNT)
	) u_first_free (
		.map   (map_q),
		.found (ff_found),
		.index (ff_index)
	);

	// Range check on the named block
	assign idx_wide = 32'(cmd_s1.block_index);
	assign in_range = idx_wide < 32'(BLOCK_COUNT);
	assign sel      = idx_wide[IDX_W-1:0];

	// Command execution
	always_comb begin
		map_d  = map_q;
		used_d = used_q;
		status = ST_OK;
		grant  = '0;
		case (cmd_s1.mode)
			MODE_ALLOC: begin
				if (ff_found) begin
					map_d[ff_index] = 1'b1;
					used_d          = used_q + CNT_W'(1);
					grant           = ff_index;
				end else begin
					status = ST_NO_FREE;
				end
			end
			MODE_REQUEST: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else if (map_q[sel]) begin
					status = ST_USED;
				end else begin
					map_d[sel] = 1'b1;
					used_d     = used_q + CNT_W'(1);
				end
			end
			MODE_RELEASE: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else if (map_q[sel]) begin
					map_d[sel] = 1'b0;
					used_d     = used_q - CNT_W'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Response fields, counts masked to the field width
	always_comb begin
		rsp_d.status        = status;
		rsp_d.granted_index = GRANT_W'(grant);
		rsp_d.used_count    = COUNT_W'(used_d);
		rsp_d.free_count    = COUNT_W'(32'(BLOCK_COUNT) - 32'(used_d));
	end

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// Bitmap, count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q     <= '0;
			used_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				map_q  <= map_d;
				used_q <= used_d;
			end
			if (advance) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// The count always matches the number of set bits in the bitmap
	a_count_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) == 32'($countones(map_q)))
		else $error("used count disagrees with bitmap");

	// The count never exceeds the number of blocks
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(BLOCK_COUNT))
		else $error("used count above block count");

	// The count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (used_q == $past(used_q)) || (used_q == $past(used_q) + CNT_W'(1))
			|| (used_q == $past(used_q) - CNT_W'(1)))
		else $error("used count jumped");

	// A held command is not overwritten while the response slot is full
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_vld_s1 && !advance |=> cmd_vld_s1 && $stable(cmd_s1))
		else $error("pending command lost");

	// No free block is only reported when every block is in use
	a_no_free_full: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status == ST_NO_FREE |-> 32'(used_q) == 32'(BLOCK_COUNT))
		else $error("allocate failed with free blocks left");

endmodule

>>> tb/tb_block_allocation_bitmap.sv
`timescale 1ns / 100ps

module tb_block_allocation_bitmap;
	import bab_pkg::*;

	localparam int BLOCKS        = BLOCK_COUNT_DEF;
	localparam mode_t MODE_SPARE = mode_t'(2'd3);
	localparam int RUN_ITEMS     = 2000;
	localparam int CALM_TAIL     = 300;
	localparam int LONG_HOLD     = 300;
	localparam int LONG_HOLD_AT  = 700;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_MAX    = 40;

	typedef struct {
		cmd_t cmd;
		bit   after_drain;
	} job_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the allocation state
	bit [BLOCKS-1:0] busy_map;
	int unsigned     busy_total;

	rsp_t        replies_q[$];
	job_t        job_q[$];
	job_t        next_job;
	rsp_t        exp_rsp;
	bit          drain_mark;
	bit          cmd_fire;
	int unsigned total_jobs;
	int unsigned cmds_taken;
	int unsigned rsps_seen;
	int unsigned fail_count;
	int unsigned send_idle_left;
	int unsigned send_idle_pct;
	int unsigned send_epoch;
	int unsigned rsp_idle_left;
	int unsigned rsp_idle_pct;
	int unsigned rsp_epoch;
	int unsigned long_hold_left;
	bit          long_hold_done;

	block_allocation_bitmap u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow bitmap and return the reply it should give
	function automatic rsp_t run_alloc_cmd(cmd_t c);
		rsp_t        r;
		bit          placed;
		int unsigned free_left;
		r.status        = ST_OK;
		r.granted_index = '0;
		placed          = 1'b0;
		case (c.mode)
			MODE_ALLOC: begin
				r.status = ST_NO_FREE;
				for (int i = 0; i < BLOCKS; i++) begin
					if (!placed && !busy_map[i]) begin
						placed          = 1'b1;
						busy_map[i]     = 1'b1;
						busy_total++;
						r.granted_index = i[GRANT_W-1:0];
						r.status        = ST_OK;
					end
				end
			end
			MODE_REQUEST: begin
				if (c.block_index >= BLOCKS) begin
					r.status = ST_RANGE;
				end else if (busy_map[c.block_index]) begin
					r.status = ST_USED;
				end else begin
					busy_map[c.block_index] = 1'b1;
					busy_total++;
				end
			end
			MODE_RELEASE: begin
				if (c.block_index >= BLOCKS) begin
					r.status = ST_RANGE;
				end else if (busy_map[c.block_index]) begin
					busy_map[c.block_index] = 1'b0;
					busy_total--;
				end
			end
			default: begin
				// spare mode: no effect
			end
		endcase
		free_left    = BLOCKS - busy_total;
		r.used_count = busy_total[COUNT_W-1:0];
		r.free_count = free_left[COUNT_W-1:0];
		return r;
	endfunction

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 4))
			0, 1:    return 0;
			2:       return 5;
			3:       return 15;
			default: return 40;
		endcase
	endfunction

	// Mostly in range, now and then past the end of the bitmap
	function automatic int unsigned pick_index();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(BLOCKS, 511);
		return $urandom_range(0, BLOCKS - 1);
	endfunction

	task automatic queue_cmd(input mode_t m, input int unsigned idx);
		job_t j;
		j.cmd.mode        = m;
		j.cmd.block_index = idx[BIDX_W-1:0];
		j.after_drain     = drain_mark;
		drain_mark        = 1'b0;
		job_q.push_back(j);
	endtask

	// Command driver: presents queued transactions at the falling edge
	always @(negedge clk) begin
		if (cmds_taken / 100 != send_epoch) begin
			send_epoch    = cmds_taken / 100;
			send_idle_pct = pick_idle_pct();
		end
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (cmd_valid && !cmd_fire) begin
			// hold the offer until it is taken
		end else if (send_idle_left != 0) begin
			send_idle_left--;
			cmd_valid <= 1'b0;
		end else if (job_q.size() == 0 || (job_q[0].after_drain && replies_q.size() != 0)) begin
			cmd_valid <= 1'b0;
		end else if (cmds_taken + CALM_TAIL < total_jobs &&
				$urandom_range(0, 99) < send_idle_pct) begin
			send_idle_left = $urandom_range(1, 11) - 1;
			cmd_valid <= 1'b0;
		end else begin
			next_job = job_q.pop_front();
			cmd       <= next_job.cmd;
			cmd_valid <= 1'b1;
		end
		cmd_fire = 1'b0;
	end

	// Reply receiver: random stalls plus one long hold to back the block up
	always @(negedge clk) begin
		if (rsps_seen / 100 != rsp_epoch) begin
			rsp_epoch    = rsps_seen / 100;
			rsp_idle_pct = pick_idle_pct();
		end
		if (!long_hold_done && rsps_seen >= LONG_HOLD_AT) begin
			long_hold_left = LONG_HOLD;
			long_hold_done = 1'b1;
		end
		if (long_hold_left != 0) begin
			long_hold_left--;
			rsp_ready <= 1'b0;
		end else if (rsp_idle_left != 0) begin
			rsp_idle_left--;
			rsp_ready <= 1'b0;
		end else if (rsps_seen + CALM_TAIL < total_jobs &&
				$urandom_range(0, 99) < rsp_idle_pct) begin
			rsp_idle_left = $urandom_range(1, 11) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Monitor: check replies against predictions, predict on each accepted command
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsps_seen++;
				if (replies_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: unexpected reply, status %0d grant %0d used %0d free %0d",
							$time, rsp.status, rsp.granted_index, rsp.used_count,
							rsp.free_count);
				end else begin
					exp_rsp = replies_q.pop_front();
					if (rsp.status !== exp_rsp.status ||
							rsp.granted_index !== exp_rsp.granted_index ||
							rsp.used_count !== exp_rsp.used_count ||
							rsp.free_count !== exp_rsp.free_count) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display({"%0t: reply mismatch, expected status %0d grant %0d",
								" used %0d free %0d, got status %0d grant %0d used %0d",
								" free %0d"}, $time, exp_rsp.status,
								exp_rsp.granted_index, exp_rsp.used_count,
								exp_rsp.free_count, rsp.status, rsp.granted_index,
								rsp.used_count, rsp.free_count);
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				replies_q.push_back(run_alloc_cmd(cmd));
				cmds_taken++;
				cmd_fire = 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("block_allocation_bitmap test failed");
		$finish;
	end

	initial begin
		int          order [BLOCKS];
		int          swap_at;
		int          hold;
		int unsigned alloc_w;
		int unsigned pick;

		// Directed: empty map, range edges, double request, release of a free block
		queue_cmd(MODE_ALLOC, 0);
		queue_cmd(MODE_ALLOC, 511);
		queue_cmd(MODE_REQUEST, BLOCKS - 1);
		queue_cmd(MODE_REQUEST, BLOCKS - 1);
		queue_cmd(MODE_REQUEST, BLOCKS);
		queue_cmd(MODE_REQUEST, 511);
		queue_cmd(MODE_RELEASE, BLOCKS);
		queue_cmd(MODE_RELEASE, 511);
		queue_cmd(MODE_RELEASE, 100);
		queue_cmd(MODE_RELEASE, 0);
		queue_cmd(MODE_ALLOC, 0);
		queue_cmd(MODE_SPARE, 511);
		queue_cmd(MODE_SPARE, 0);
		queue_cmd(MODE_REQUEST, 0);
		queue_cmd(MODE_RELEASE, BLOCKS - 1);
		queue_cmd(MODE_REQUEST, 170);
		queue_cmd(MODE_REQUEST, 85);
		queue_cmd(MODE_RELEASE, 170);
		queue_cmd(MODE_RELEASE, 85);
		queue_cmd(MODE_RELEASE, 1);
		queue_cmd(MODE_RELEASE, 0);

		// Fill the whole map, run past full, then punch one hole and refill it
		drain_mark = 1'b1;
		repeat (BLOCKS + 10) queue_cmd(MODE_ALLOC, $urandom_range(0, 511));
		queue_cmd(MODE_REQUEST, 17);
		queue_cmd(MODE_RELEASE, 17);
		queue_cmd(MODE_ALLOC, 0);
		queue_cmd(MODE_ALLOC, 0);

		// Empty the map again in shuffled order
		for (int i = 0; i < BLOCKS; i++)
			order[i] = i;
		for (int i = BLOCKS - 1; i > 0; i--) begin
			swap_at        = $urandom_range(0, i);
			hold           = order[i];
			order[i]       = order[swap_at];
			order[swap_at] = hold;
		end
		drain_mark = 1'b1;
		for (int i = 0; i < BLOCKS; i++)
			queue_cmd(MODE_RELEASE, order[i]);

		// Random mix; allocate weight swings so occupancy wanders high and low
		alloc_w = 30;
		while (job_q.size() < RUN_ITEMS) begin
			if (job_q.size() % 100 == 0)
				alloc_w = $urandom_range(5, 60);
			pick = $urandom_range(0, 99);
			if (pick < alloc_w)
				queue_cmd(MODE_ALLOC, $urandom_range(0, 511));
			else if (pick < alloc_w + 15)
				queue_cmd(MODE_REQUEST, pick_index());
			else if (pick < 95)
				queue_cmd(MODE_RELEASE, pick_index());
			else
				queue_cmd(MODE_SPARE, $urandom_range(0, 511));
		end
		total_jobs = job_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmds_taken < total_jobs) @(posedge clk);
		while (replies_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("block_allocation_bitmap test passed");
		else
			$display("block_allocation_bitmap test failed");
		$finish;
	end

endmodule
